// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the color matrix block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that post holds in the same cycle as pre.
`define ASSERT_SAME_CYCLE(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Check that post holds in the cycle after pre.
`define ASSERT_NEXT_CYCLE(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hw/rtl/cmcc_pkg.sv =====
// Package with widths, codes and word types of the color matrix convert and clamp block.
package cmcc_pkg;

    // Field and register widths
    localparam int CHANNEL_BITS   = 10;
    localparam int COEFF_BITS     = 20;
    localparam int SLOT_STRIDE    = 20;
    localparam int CFG_BITS       = 60;
    localparam int SHIFT_BITS     = 4;
    localparam int MODE_BITS      = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int ROWS           = 3;
    localparam int POST_SHIFT     = 8;

    // Datapath widths: product of an unsigned channel and a signed coefficient,
    // sum of three products, then the row offset added
    localparam int PROD_BITS = CHANNEL_BITS + 1 + COEFF_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;
    localparam int OFS_BITS  = SUM_BITS + 1;

    localparam logic [CHANNEL_BITS-1:0] CLAMP_HIGH_RESET = {CHANNEL_BITS{1'b1}};

    // Register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_COEFF_COLUMN_0 = 3'd0,
        REG_COEFF_COLUMN_1 = 3'd1,
        REG_COEFF_COLUMN_2 = 3'd2,
        REG_OFFSET_COLUMN  = 3'd3,
        REG_PRODUCT_SHIFT  = 3'd4,
        REG_CLAMP_LOW      = 3'd5,
        REG_CLAMP_HIGH     = 3'd6,
        REG_OUTPUT_MODE    = 3'd7
    } cfg_reg_t;

    // Output mode codes; the unused code converts in plain order
    localparam logic [MODE_BITS-1:0] MODE_BYPASS = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_PLAIN  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_SWAP   = 2'd2;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] in_red;
        logic [CHANNEL_BITS-1:0] in_green;
        logic [CHANNEL_BITS-1:0] in_blue;
        logic [CHANNEL_BITS-1:0] in_alpha;
    } pixel_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] out_first;
        logic [CHANNEL_BITS-1:0] out_second;
        logic [CHANNEL_BITS-1:0] out_third;
        logic [CHANNEL_BITS-1:0] out_alpha;
    } result_t;

endpackage

// ===== hw/rtl/color_matrix_convert_clamp.sv =====
// Top level: four-stage 3x4 color matrix with offset, shift and clamp.
//
//  channel  | direction | handshake                  | word
//  ---------+-----------+----------------------------+-------------------------
//  pixel    | in        | pixel_valid / pixel_stall  | pixel_word (r, g, b, a)
//  result   | out       | result_valid / result_stall| result_word (3 rows, a)
//  cfg      | in        | cfg_write_en               | cfg_index, cfg_data
//
// One pixel enters per cycle while pixel_stall is low; each result passes the stages in order
// (products, row sums, shift plus offset, final shift plus clamp).
// Reset clears all valid bits and loads register reset values; no clearing pass.
// A stalled result holds only the stages behind it that are full; empty stages
// keep filling, so pixel_stall rises only when all four stages hold a word.
`include "assert_macros.svh"

module color_matrix_convert_clamp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  cmcc_pkg::pixel_t                    pixel_word,
    output logic                                result_valid,
    input  logic                                result_stall,
    output cmcc_pkg::result_t                   result_word,
    input  logic                                cfg_write_en,
    input  logic [cmcc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [cmcc_pkg::CFG_BITS-1:0]       cfg_data
);
    import cmcc_pkg::*;

    // Configuration registers
    logic [CFG_BITS-1:0]     coeff_reg [ROWS];
    logic [CFG_BITS-1:0]     offset_reg;
    logic [SHIFT_BITS-1:0]   shift_reg;
    logic [CHANNEL_BITS-1:0] clamp_low_reg;
    logic [CHANNEL_BITS-1:0] clamp_high_reg;
    logic [MODE_BITS-1:0]    mode_reg;

    // Pipeline registers
    logic                       s1_valid_reg, s2_valid_reg, s3_valid_reg, result_valid_reg;
    pixel_t                     s1_pixel_reg, s2_pixel_reg, s3_pixel_reg;
    logic signed [PROD_BITS-1:0] prod_reg [ROWS][ROWS];
    logic signed [PROD_BITS-1:0] prod_next [ROWS][ROWS];
    logic signed [SUM_BITS-1:0]  sum_reg [ROWS];
    logic signed [SUM_BITS-1:0]  sum_next [ROWS];
    logic signed [OFS_BITS-1:0]  ofs_reg [ROWS];
    logic signed [OFS_BITS-1:0]  ofs_next [ROWS];
    result_t                     result_reg;
    result_t                     result_next;

    logic                    ready1, ready2, ready3, ready4;
    logic [CHANNEL_BITS-1:0] chan [ROWS];
    logic [CHANNEL_BITS-1:0] row_val [ROWS];

    // Signed coefficient or offset of one row from a packed column word
    function automatic logic signed [COEFF_BITS-1:0] slot_of(
        input logic [CFG_BITS-1:0] word,
        input int                  row
    );
        logic signed [COEFF_BITS-1:0] val;
        begin
            val = word[row*SLOT_STRIDE +: COEFF_BITS];
            return val;
        end
    endfunction

    // Clamp a signed value to the bounds; when they cross, only values below the low bound get it
    function automatic logic [CHANNEL_BITS-1:0] clamp_of(
        input logic signed [OFS_BITS-1:0] v,
        input logic [CHANNEL_BITS-1:0]    lo,
        input logic [CHANNEL_BITS-1:0]    hi
    );
        logic signed [OFS_BITS-1:0] lo_s;
        logic signed [OFS_BITS-1:0] hi_s;
        begin
            lo_s = $signed({{(OFS_BITS-CHANNEL_BITS){1'b0}}, lo});
            hi_s = $signed({{(OFS_BITS-CHANNEL_BITS){1'b0}}, hi});
            if (v < lo_s)
            begin
                return lo;
            end
            else if (v > hi_s)
            begin
                return hi;
            end
            else
            begin
                return v[CHANNEL_BITS-1:0];
            end
        end
    endfunction

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < ROWS; c++)
            begin
                coeff_reg[c] <= '0;
            end
            offset_reg     <= '0;
            shift_reg      <= '0;
            clamp_low_reg  <= '0;
            clamp_high_reg <= CLAMP_HIGH_RESET;
            mode_reg       <= MODE_BYPASS;
        end
        else if (cfg_write_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_COEFF_COLUMN_0: coeff_reg[0]   <= cfg_data;
                REG_COEFF_COLUMN_1: coeff_reg[1]   <= cfg_data;
                REG_COEFF_COLUMN_2: coeff_reg[2]   <= cfg_data;
                REG_OFFSET_COLUMN:  offset_reg     <= cfg_data;
                REG_PRODUCT_SHIFT:  shift_reg      <= cfg_data[SHIFT_BITS-1:0];
                REG_CLAMP_LOW:      clamp_low_reg  <= cfg_data[CHANNEL_BITS-1:0];
                REG_CLAMP_HIGH:     clamp_high_reg <= cfg_data[CHANNEL_BITS-1:0];
                REG_OUTPUT_MODE:    mode_reg       <= cfg_data[MODE_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // Advance a stage when it is empty or the stage after it moves
    assign ready4      = !result_valid_reg || !result_stall;
    assign ready3      = !s3_valid_reg || ready4;
    assign ready2      = !s2_valid_reg || ready3;
    assign ready1      = !s1_valid_reg || ready2;
    assign pixel_stall = !ready1;

    // Stage 1: one product per row and column
    assign chan[0] = pixel_word.in_red;
    assign chan[1] = pixel_word.in_green;
    assign chan[2] = pixel_word.in_blue;

    always_comb
    begin
        for (int k = 0; k < ROWS; k++)
        begin
            for (int c = 0; c < ROWS; c++)
            begin
                prod_next[k][c] = PROD_BITS'($signed({1'b0, chan[c]}))
                                * PROD_BITS'(slot_of(coeff_reg[c], k));
            end
        end
    end

    // Stage 2: sum the three products of each row
    always_comb
    begin
        for (int k = 0; k < ROWS; k++)
        begin
            sum_next[k] = SUM_BITS'(prod_reg[k][0]) + SUM_BITS'(prod_reg[k][1])
                        + SUM_BITS'(prod_reg[k][2]);
        end
    end

    // Stage 3: arithmetic shift of the sum, then add the row offset
    always_comb
    begin
        logic signed [SUM_BITS-1:0] scaled;
        for (int k = 0; k < ROWS; k++)
        begin
            scaled      = sum_reg[k] >>> shift_reg;
            ofs_next[k] = OFS_BITS'(scaled) + OFS_BITS'(slot_of(offset_reg, k));
        end
    end

    // Stage 4: final shift, clamp, channel order or bypass
    always_comb
    begin
        logic signed [OFS_BITS-1:0] post;
        for (int k = 0; k < ROWS; k++)
        begin
            post       = ofs_reg[k] >>> POST_SHIFT;
            row_val[k] = clamp_of(post, clamp_low_reg, clamp_high_reg);
        end
        if (mode_reg == MODE_BYPASS)
        begin
            result_next.out_first  = s3_pixel_reg.in_red;
            result_next.out_second = s3_pixel_reg.in_green;
            result_next.out_third  = s3_pixel_reg.in_blue;
            result_next.out_alpha  = s3_pixel_reg.in_alpha;
        end
        else
        begin
            result_next.out_first  = (mode_reg == MODE_SWAP) ? row_val[2] : row_val[0];
            result_next.out_second = row_val[1];
            result_next.out_third  = (mode_reg == MODE_SWAP) ? row_val[0] : row_val[2];
            result_next.out_alpha  = clamp_of(
                $signed({{(OFS_BITS-CHANNEL_BITS){1'b0}}, s3_pixel_reg.in_alpha}),
                clamp_low_reg, clamp_high_reg);
        end
    end

    // Valid bits travel with the words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                s1_valid_reg <= pixel_valid;
            end
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (ready4)
            begin
                result_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Load stage data only when a word moves in
    always_ff @(posedge clk)
    begin
        if (ready1 && pixel_valid)
        begin
            s1_pixel_reg <= pixel_word;
            prod_reg     <= prod_next;
        end
        if (ready2 && s1_valid_reg)
        begin
            s2_pixel_reg <= s1_pixel_reg;
            sum_reg      <= sum_next;
        end
        if (ready3 && s2_valid_reg)
        begin
            s3_pixel_reg <= s2_pixel_reg;
            ofs_reg      <= ofs_next;
        end
        if (ready4 && s3_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_word  = result_reg;

    // Input stalls only with every stage full and the output blocked
    `ASSERT_SAME_CYCLE(a_stall_only_when_full, pixel_stall,
        s1_valid_reg && s2_valid_reg && s3_valid_reg && result_valid_reg && result_stall,
        "pixel_stall raised while a pipeline stage is free")

    // A word in the last stage reaches the output when the output frees up
    `ASSERT_NEXT_CYCLE(a_stage3_drains, s3_valid_reg && ready4, result_valid_reg,
        "word in stage 3 lost on its way to the output")

    // Converted alpha stays within ordered clamp bounds
    `ASSERT_SAME_CYCLE(a_alpha_in_bounds,
        result_valid_reg && (mode_reg != MODE_BYPASS) && (clamp_low_reg <= clamp_high_reg),
        (result_reg.out_alpha >= clamp_low_reg) && (result_reg.out_alpha <= clamp_high_reg),
        "alpha outside clamp bounds")

endmodule

// ===== tb/cmcc_check_pkg.sv =====
// Scoreboard class that predicts and checks color matrix result words.
package cmcc_check_pkg;

    import cmcc_pkg::*;

    class conversion_scoreboard;

        // Register image as the block holds it
        logic [CFG_BITS-1:0]     coeff_col [ROWS];
        logic [CFG_BITS-1:0]     offset_col;
        logic [SHIFT_BITS-1:0]   shift;
        logic [CHANNEL_BITS-1:0] clamp_lo;
        logic [CHANNEL_BITS-1:0] clamp_hi;
        logic [MODE_BITS-1:0]    mode;

        result_t converted_q [$];
        int      errors;

        function new();
            coeff_col  = '{default: '0};
            offset_col = '0;
            shift      = '0;
            clamp_lo   = '0;
            clamp_hi   = CLAMP_HIGH_RESET;
            mode       = MODE_BYPASS;
            errors     = 0;
        endfunction

        // Keep only the bits each register holds
        function void write_reg(cfg_reg_t idx, logic [CFG_BITS-1:0] data);
            case (idx)
                REG_COEFF_COLUMN_0: coeff_col[0] = data;
                REG_COEFF_COLUMN_1: coeff_col[1] = data;
                REG_COEFF_COLUMN_2: coeff_col[2] = data;
                REG_OFFSET_COLUMN:  offset_col   = data;
                REG_PRODUCT_SHIFT:  shift        = data[SHIFT_BITS-1:0];
                REG_CLAMP_LOW:      clamp_lo     = data[CHANNEL_BITS-1:0];
                REG_CLAMP_HIGH:     clamp_hi     = data[CHANNEL_BITS-1:0];
                REG_OUTPUT_MODE:    mode         = data[MODE_BITS-1:0];
                default:            ;
            endcase
        endfunction

        function longint slot_value(logic [CFG_BITS-1:0] column, int row);
            logic signed [COEFF_BITS-1:0] raw;
            raw = column[row*SLOT_STRIDE +: COEFF_BITS];
            return longint'(raw);
        endfunction

        // When the bounds cross, only values below the low bound get it; all others get the high bound
        function logic [CHANNEL_BITS-1:0] clamp_channel(longint v);
            if (v < longint'(clamp_lo))
                return clamp_lo;
            if (v > longint'(clamp_hi))
                return clamp_hi;
            return v[CHANNEL_BITS-1:0];
        endfunction

        function logic [CHANNEL_BITS-1:0] convert_row(int row, pixel_t p);
            longint sum;
            longint v;
            sum = longint'(p.in_red)   * slot_value(coeff_col[0], row)
                + longint'(p.in_green) * slot_value(coeff_col[1], row)
                + longint'(p.in_blue)  * slot_value(coeff_col[2], row);
            v = sum >>> shift;
            v = v + slot_value(offset_col, row);
            v = v >>> POST_SHIFT;
            return clamp_channel(v);
        endfunction

        // Queue the word this pixel must produce
        function void note_pixel(pixel_t p);
            result_t                 want;
            logic [CHANNEL_BITS-1:0] row0;
            logic [CHANNEL_BITS-1:0] row2;
            if (mode == MODE_BYPASS)
            begin
                want.out_first  = p.in_red;
                want.out_second = p.in_green;
                want.out_third  = p.in_blue;
                want.out_alpha  = p.in_alpha;
            end
            else
            begin
                row0 = convert_row(0, p);
                row2 = convert_row(2, p);
                want.out_first  = (mode == MODE_SWAP) ? row2 : row0;
                want.out_second = convert_row(1, p);
                want.out_third  = (mode == MODE_SWAP) ? row0 : row2;
                want.out_alpha  = clamp_channel(longint'(p.in_alpha));
            end
            converted_q.push_back(want);
        endfunction

        function void compare_field(string name, logic [CHANNEL_BITS-1:0] want,
                                    logic [CHANNEL_BITS-1:0] got, time stamp);
            if (got !== want)
            begin
                $display("%0t: %s expected %0d got %0d", stamp, name, want, got);
                errors++;
            end
        endfunction

        // Match a result word against the oldest pending one
        function void check_result(result_t got, time stamp);
            result_t want;
            if (converted_q.size() == 0)
            begin
                $display("%0t: result word %h with no pixel pending", stamp, got);
                errors++;
                return;
            end
            want = converted_q.pop_front();
            compare_field("out_first",  want.out_first,  got.out_first,  stamp);
            compare_field("out_second", want.out_second, got.out_second, stamp);
            compare_field("out_third",  want.out_third,  got.out_third,  stamp);
            compare_field("out_alpha",  want.out_alpha,  got.out_alpha,  stamp);
        endfunction

        function int pending();
            return converted_q.size();
        endfunction

    endclass

endpackage

// ===== tb/testbench.sv =====
// Testbench top: drives pixels and register writes into the color matrix block and checks results.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import cmcc_pkg::*;
    import cmcc_check_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 16;
    localparam int MAX_IDLE      = 11;

    localparam logic [COEFF_BITS-1:0] SLOT_MAX    = 20'h7FFFF;
    localparam logic [COEFF_BITS-1:0] SLOT_MIN    = 20'h80000;
    localparam logic [COEFF_BITS-1:0] SLOT_UNIT   = 20'd256;
    localparam logic [MODE_BITS-1:0]  MODE_UNUSED = 2'd3;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      pixel_valid  = 1'b0;
    logic                      pixel_stall;
    pixel_t                    pixel_word   = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    result_t                   result_word;
    logic                      cfg_write_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = REG_COEFF_COLUMN_0;
    logic [CFG_BITS-1:0]       cfg_data     = '0;

    logic [CFG_BITS-1:0]  reg_image [8];
    bit                   send_idle_on = 1'b1;
    bit                   take_idle_on = 1'b1;
    int unsigned          stall_left   = 0;
    int                   cycle_count  = 0;
    conversion_scoreboard board        = new();

    color_matrix_convert_clamp dut (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Take result words, then hold stall for a drawn number of cycles
    always @(posedge clk)
    begin : take_results
        int unsigned hold;
        if (result_valid && !result_stall)
        begin
            board.check_result(result_word, $time);
            hold = take_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            stall_left   <= hold;
            result_stall <= (hold != 0);
        end
        else if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            result_stall <= (stall_left > 1);
        end
    end

    function automatic logic [CFG_BITS-1:0] pack_slots(logic [COEFF_BITS-1:0] row0,
                                                       logic [COEFF_BITS-1:0] row1,
                                                       logic [COEFF_BITS-1:0] row2);
        return {row2, row1, row0};
    endfunction

    function automatic pixel_t make_pixel(logic [CHANNEL_BITS-1:0] r, logic [CHANNEL_BITS-1:0] g,
                                          logic [CHANNEL_BITS-1:0] b, logic [CHANNEL_BITS-1:0] a);
        pixel_t p;
        p.in_red   = r;
        p.in_green = g;
        p.in_blue  = b;
        p.in_alpha = a;
        return p;
    endfunction

    // Lean toward the field extremes
    function automatic logic [CHANNEL_BITS-1:0] random_channel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return CHANNEL_BITS'($urandom());
        endcase
    endfunction

    // Scale half of the coefficients so the rows land near the output range
    function automatic logic [COEFF_BITS-1:0] random_coeff(int unsigned shift);
        int unsigned span;
        span = 1 << ((shift + 7 > 19) ? 19 : shift + 7);
        case ($urandom_range(0, 9))
            0:       return SLOT_MAX;
            1:       return SLOT_MIN;
            2:       return '0;
            3, 4:    return COEFF_BITS'($urandom());
            default: return COEFF_BITS'($urandom_range(0, 2 * span - 1) - span);
        endcase
    endfunction

    function automatic logic [COEFF_BITS-1:0] random_offset();
        case ($urandom_range(0, 7))
            0:       return SLOT_MAX;
            1:       return SLOT_MIN;
            2:       return '0;
            3:       return COEFF_BITS'($urandom());
            default: return COEFF_BITS'($urandom_range(0, (1 << 18) - 1) - (1 << 17));
        endcase
    endfunction

    // Draw a full register set; narrow registers carry noise above their width
    function automatic void randomize_registers();
        int unsigned             shift;
        logic [CHANNEL_BITS-1:0] lo;
        logic [CHANNEL_BITS-1:0] hi;
        shift = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 15 : 0)
                                            : $urandom_range(0, 15);
        reg_image[REG_COEFF_COLUMN_0] =
            pack_slots(random_coeff(shift), random_coeff(shift), random_coeff(shift));
        reg_image[REG_COEFF_COLUMN_1] =
            pack_slots(random_coeff(shift), random_coeff(shift), random_coeff(shift));
        reg_image[REG_COEFF_COLUMN_2] =
            pack_slots(random_coeff(shift), random_coeff(shift), random_coeff(shift));
        reg_image[REG_OFFSET_COLUMN] =
            pack_slots(random_offset(), random_offset(), random_offset());
        case ($urandom_range(0, 4))
            0:
            begin
                lo = '0;
                hi = '1;
            end
            1:
            begin
                lo = CHANNEL_BITS'($urandom());
                hi = lo;
            end
            2:
            begin
                lo = CHANNEL_BITS'($urandom());
                hi = CHANNEL_BITS'($urandom());
            end
            3:
            begin
                lo = '1;
                hi = '0;
            end
            default:
            begin
                lo = CHANNEL_BITS'($urandom_range(0, 400));
                hi = CHANNEL_BITS'($urandom_range(600, 1023));
            end
        endcase
        reg_image[REG_PRODUCT_SHIFT] = CFG_BITS'({$urandom(), $urandom()});
        reg_image[REG_PRODUCT_SHIFT][SHIFT_BITS-1:0] = SHIFT_BITS'(shift);
        reg_image[REG_CLAMP_LOW] = CFG_BITS'({$urandom(), $urandom()});
        reg_image[REG_CLAMP_LOW][CHANNEL_BITS-1:0] = lo;
        reg_image[REG_CLAMP_HIGH] = CFG_BITS'({$urandom(), $urandom()});
        reg_image[REG_CLAMP_HIGH][CHANNEL_BITS-1:0] = hi;
        reg_image[REG_OUTPUT_MODE] = CFG_BITS'({$urandom(), $urandom()});
        case ($urandom_range(0, 6))
            0:       reg_image[REG_OUTPUT_MODE][MODE_BITS-1:0] = MODE_BYPASS;
            1:       reg_image[REG_OUTPUT_MODE][MODE_BITS-1:0] = MODE_UNUSED;
            2, 3:    reg_image[REG_OUTPUT_MODE][MODE_BITS-1:0] = MODE_SWAP;
            default: reg_image[REG_OUTPUT_MODE][MODE_BITS-1:0] = MODE_PLAIN;
        endcase
    endfunction

    // Write every register from the image, one per cycle
    task automatic load_registers();
        cfg_reg_t idx;
        idx = idx.first();
        do
        begin
            cfg_write_en <= 1'b1;
            cfg_index    <= idx;
            cfg_data     <= reg_image[idx];
            @(posedge clk);
            board.write_reg(idx, reg_image[idx]);
            idx = idx.next();
        end
        while (idx != idx.first());
        cfg_write_en <= 1'b0;
    endtask

    // Offer one word after a drawn gap and hold it until taken
    task automatic send_pixel(pixel_t p);
        int unsigned gap;
        gap = send_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        repeat (gap)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_word  <= p;
        do @(posedge clk); while (pixel_stall);
        board.note_pixel(p);
    endtask

    // Stop sending until every pending word has come back
    task automatic drain();
        pixel_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    task automatic set_clamp_mode(logic [CHANNEL_BITS-1:0] lo, logic [CHANNEL_BITS-1:0] hi,
                                  logic [MODE_BITS-1:0] mode);
        reg_image[REG_CLAMP_LOW]   = CFG_BITS'(lo);
        reg_image[REG_CLAMP_HIGH]  = CFG_BITS'(hi);
        reg_image[REG_OUTPUT_MODE] = CFG_BITS'(mode);
        load_registers();
    endtask

    initial
    begin
        int unsigned count;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bypass straight out of reset
        send_pixel(make_pixel('0, '0, '0, '0));
        send_pixel(make_pixel('1, '1, '1, '1));
        send_pixel(make_pixel(10'h2AA, 10'h155, 10'h2AA, 10'h155));
        send_pixel(make_pixel(10'h155, 10'h2AA, 10'h155, 10'h2AA));
        drain();

        // Coefficients and offsets at their positive extreme
        reg_image[REG_COEFF_COLUMN_0] = pack_slots(SLOT_MAX, SLOT_MAX, SLOT_MAX);
        reg_image[REG_COEFF_COLUMN_1] = pack_slots(SLOT_MAX, SLOT_MAX, SLOT_MAX);
        reg_image[REG_COEFF_COLUMN_2] = pack_slots(SLOT_MAX, SLOT_MAX, SLOT_MAX);
        reg_image[REG_OFFSET_COLUMN]  = pack_slots(SLOT_MAX, SLOT_MAX, SLOT_MAX);
        reg_image[REG_PRODUCT_SHIFT]  = '0;
        set_clamp_mode('0, '1, MODE_PLAIN);
        send_pixel(make_pixel('0, '0, '0, '0));
        send_pixel(make_pixel('1, '1, '1, '1));
        drain();

        // Negative extremes, widest shift with noise above it, swapped order
        reg_image[REG_COEFF_COLUMN_0] = pack_slots(SLOT_MIN, SLOT_MIN, SLOT_MIN);
        reg_image[REG_COEFF_COLUMN_1] = pack_slots(SLOT_MIN, SLOT_MIN, SLOT_MIN);
        reg_image[REG_COEFF_COLUMN_2] = pack_slots(SLOT_MIN, SLOT_MIN, SLOT_MIN);
        reg_image[REG_OFFSET_COLUMN]  = pack_slots(SLOT_MIN, SLOT_MIN, SLOT_MIN);
        reg_image[REG_PRODUCT_SHIFT]  = '1;
        set_clamp_mode(10'd5, 10'd1000, MODE_SWAP);
        send_pixel(make_pixel('0, '0, '0, '0));
        send_pixel(make_pixel('1, '1, '1, '1));
        drain();

        // Unit diagonal with crossed bounds under the unused mode code
        reg_image[REG_COEFF_COLUMN_0] = pack_slots(SLOT_UNIT, '0, '0);
        reg_image[REG_COEFF_COLUMN_1] = pack_slots('0, SLOT_UNIT, '0);
        reg_image[REG_COEFF_COLUMN_2] = pack_slots('0, '0, SLOT_UNIT);
        reg_image[REG_OFFSET_COLUMN]  = '0;
        reg_image[REG_PRODUCT_SHIFT]  = '0;
        set_clamp_mode(10'd700, 10'd300, MODE_UNUSED);
        send_pixel(make_pixel(10'd100, 10'd500, 10'd900, 10'd100));
        send_pixel(make_pixel(10'd900, 10'd100, 10'd500, 10'd500));
        send_pixel(make_pixel(10'd500, 10'd900, 10'd100, 10'd900));
        drain();

        // Bypass ignores crossed bounds
        set_clamp_mode(10'd700, 10'd300, MODE_BYPASS);
        send_pixel(make_pixel(10'd100, 10'd500, 10'd900, '1));
        send_pixel(make_pixel('0, '1, '0, '0));
        drain();

        // Swapped order on the unit diagonal
        set_clamp_mode('0, '1, MODE_SWAP);
        send_pixel(make_pixel(10'd1, 10'd2, 10'd3, 10'd4));
        send_pixel(make_pixel('1, 10'd512, '0, 10'd7));
        drain();

        // Random register sets, each followed by a run of random pixels
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            randomize_registers();
            load_registers();
            send_idle_on = ($urandom_range(0, 3) != 0);
            take_idle_on = ($urandom_range(0, 3) != 0);
            count = $urandom_range(60, 150);
            repeat (count)
            begin
                send_pixel(make_pixel(random_channel(), random_channel(),
                                      random_channel(), random_channel()));
                if ($urandom_range(0, 39) == 0)
                    drain();
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
